/* rtl/fbpa_pkg.sv */
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// no dependencies; imported by every rtl file of the block but fbpa_ram

package fbpa_pkg;

    localparam int CNT_W   = 9;
    localparam int PADDR_W = 4;

    localparam logic [8:0]  MIN_BLOCKS    = 9'd2;
    localparam logic [15:0] POINTER_BYTES = 16'd8;

    // register indexes, byte address 4*i
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_TOTAL = 2'd2;

    localparam logic [15:0] RESET_BLOCK_BYTES = 16'd8;

    // iteration counts of the shared add/sub unit
    localparam int DIV_STEPS = 32;
    localparam int MUL_STEPS = 16;

    typedef enum logic [1:0] {
        CMD_GET = 2'd0,
        CMD_PUT = 2'd1,
        CMD_FMT = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_BASE  = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_TOO_SMALL = 3'd3,
        ST_NO_FREE   = 3'd4,
        ST_INVALID   = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] return_address;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic        pool_full;
        logic [31:0] granted_address;
        logic [8:0]  free_blocks;
        logic [8:0]  used_blocks;
    } t_out_word;

    typedef enum logic {
        ARITH_MUL = 1'b0,
        ARITH_DIV = 1'b1
    } t_arith_op;

    typedef struct packed {
        logic        start;
        t_arith_op   op;
        logic [31:0] a;     // dividend, or multiplicand (block index)
        logic [15:0] b;     // divisor, or multiplier (block size)
        logic [31:0] init;  // accumulator start value for multiply
    } t_arith_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
        logic [15:0] rem;
    } t_arith_rsp;

endpackage

/* rtl/fbpa_ram.sv */
// fbpa_ram: generic single-write, single-read ram with registered read data
// no dependencies

module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fbpa_arith.sv */
// fbpa_arith: iterative unit around one 32-bit adder; restoring divide or shift-add multiply
// depends on fbpa_pkg

module fbpa_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbpa_pkg::t_arith_req i_req,
    output fbpa_pkg::t_arith_rsp o_rsp
);
    import fbpa_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_arith_op   r_op;
    logic [4:0]  r_cnt;
    logic [31:0] r_acc;
    logic [15:0] r_rem;
    logic [15:0] r_b;
    logic [31:0] r_mcand;

    logic [16:0] trial;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] sum;
    logic        ge;
    logic [4:0]  last;

    always_comb begin
        trial = {r_rem, r_acc[31]};
        if (r_op == ARITH_DIV) begin
            add_x   = {15'd0, trial};
            add_y   = ~{16'd0, r_b};
            add_cin = 1'b1;
        end else begin
            add_x   = r_acc;
            add_y   = r_b[0] ? r_mcand : 32'd0;
            add_cin = 1'b0;
        end
        sum  = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
        // carry out of x + ~b + 1 means no borrow
        ge   = sum[32];
        last = (r_op == ARITH_DIV) ? 5'(DIV_STEPS - 1) : 5'(MUL_STEPS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == last);
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_req.op;
                r_cnt   <= 5'd0;
                r_b     <= i_req.b;
                r_rem   <= 16'd0;
                r_mcand <= i_req.a;
                r_acc   <= (i_req.op == ARITH_DIV) ? i_req.a : i_req.init;
            end else if (r_busy) begin
                if (r_op == ARITH_DIV) begin
                    r_rem <= ge ? sum[15:0] : trial[15:0];
                    r_acc <= {r_acc[30:0], ge};
                end else begin
                    r_acc   <= sum[31:0];
                    r_b     <= {1'b0, r_b[15:1]};
                    r_mcand <= {r_mcand[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;
    assign o_rsp.rem    = r_rem;

endmodule

/* rtl/fixed_block_pool_allocator_core.sv */
// channel  | direction | handshake                  | word
// ---------+-----------+----------------------------+---------------------------
// in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_word)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_word)
// cfg      | input     | apb psel/penable, pready=1 | paddr, pwdata, prdata
//
// get runs 16 shift-add steps for base + index * size, put runs 32 restoring divide
// steps of the address offset; both run on one shared adder. format writes one link
// per cycle into the link ram. a rejected command skips the arithmetic and goes
// straight to the result. the input is taken again once the result
// sits in the output register, so a stalled output holds at most one item back.
// synchronous active-low reset; the link ram needs no clearing pass.
// depends on fbpa_pkg, fbpa_ram, fbpa_arith

module fixed_block_pool_allocator_core #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  fbpa_pkg::t_in_word               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output fbpa_pkg::t_out_word              o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import fbpa_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_GET,
        S_PUT,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [31:0] r_base_cfg;
    logic [15:0] r_size_cfg;
    logic [8:0]  r_total_cfg;

    logic [LW-1:0] r_head;
    logic [8:0]    r_free;
    logic [8:0]    r_act_total;
    logic [31:0]   r_act_base;
    logic [15:0]   r_act_size;

    logic [AW-1:0] r_fcnt;
    t_status       r_status;
    logic          r_full;
    logic [31:0]   r_granted;
    t_out_word     r_out;
    logic          r_ovalid;

    logic          cfg_wr;
    logic          in_acc;
    logic          get_ok;
    logic          put_ok;
    logic          fmt_last;
    logic          put_bad;
    logic          put_full;
    t_status       fmt_status;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic          ram_re;
    logic [LW-1:0] ram_rdata;

    t_arith_req    arith_req;
    t_arith_rsp    arith_rsp;

    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign get_ok   = (r_free != 9'd0) && (r_head < NULL_LINK);
    assign put_ok   = (r_act_total != 9'd0) && (r_act_size != 16'd0);
    assign fmt_last = (CW'(r_fcnt) + CW'(1)) == CW'(r_total_cfg);
    assign put_bad  = (arith_rsp.rem != 16'd0) || (arith_rsp.result >= 32'(r_act_total));
    assign put_full = (r_free >= r_act_total);

    // format checks run in order: base, count, size
    always_comb begin
        if (r_base_cfg == 32'd0) begin
            fmt_status = ST_BAD_BASE;
        end else if (r_total_cfg < MIN_BLOCKS || int'(r_total_cfg) > NUM_BLOCKS) begin
            fmt_status = ST_BAD_COUNT;
        end else if (r_size_cfg < POINTER_BYTES) begin
            fmt_status = ST_TOO_SMALL;
        end else begin
            fmt_status = ST_OK;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:  prdata = r_base_cfg;
            REG_SIZE:  prdata = 32'(r_size_cfg);
            REG_TOTAL: prdata = 32'(r_total_cfg);
            default:   prdata = 32'd0;
        endcase
    end

    always_comb begin
        arith_req.start = 1'b0;
        arith_req.op    = ARITH_MUL;
        arith_req.a     = 32'(r_head);
        arith_req.b     = r_act_size;
        arith_req.init  = r_act_base;
        if (in_acc && i_in_data.cmd == CMD_GET && get_ok) begin
            arith_req.start = 1'b1;
        end
        if (i_in_data.cmd == CMD_PUT) begin
            arith_req.op = ARITH_DIV;
            arith_req.a  = i_in_data.return_address - r_act_base;
            if (in_acc && put_ok) begin
                arith_req.start = 1'b1;
            end
        end
    end

    // the head's successor is fetched while the multiply runs
    assign ram_re = in_acc && (i_in_data.cmd == CMD_GET);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fcnt;
        ram_wdata = fmt_last ? NULL_LINK : LW'(r_fcnt) + LW'(1);
        if (r_state == S_FMT) begin
            ram_we = 1'b1;
        end else if (r_state == S_PUT) begin
            ram_waddr = arith_rsp.result[AW-1:0];
            ram_wdata = r_head;
            ram_we    = arith_rsp.done && !put_bad && !put_full;
        end
    end

    fbpa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    fbpa_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_base_cfg  <= 32'd0;
            r_size_cfg  <= RESET_BLOCK_BYTES;
            r_total_cfg <= 9'd0;
            r_head      <= NULL_LINK;
            r_free      <= 9'd0;
            r_act_total <= 9'd0;
            r_act_base  <= 32'd0;
            r_act_size  <= 16'd0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_BASE:  r_base_cfg  <= pwdata;
                    REG_SIZE:  r_size_cfg  <= pwdata[15:0];
                    REG_TOTAL: r_total_cfg <= pwdata[8:0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_full    <= 1'b0;
                        r_granted <= 32'd0;
                        case (i_in_data.cmd)
                            CMD_GET: begin
                                r_status <= get_ok ? ST_OK : ST_NO_FREE;
                                r_state  <= get_ok ? S_GET : S_DONE;
                            end
                            CMD_PUT: begin
                                r_status <= put_ok ? ST_OK : ST_INVALID;
                                r_state  <= put_ok ? S_PUT : S_DONE;
                            end
                            CMD_FMT: begin
                                r_status <= fmt_status;
                                r_fcnt   <= '0;
                                r_state  <= (fmt_status == ST_OK) ? S_FMT : S_DONE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FMT: begin
                    r_fcnt <= r_fcnt + AW'(1);
                    if (fmt_last) begin
                        r_head      <= '0;
                        r_free      <= r_total_cfg;
                        r_act_total <= r_total_cfg;
                        r_act_base  <= r_base_cfg;
                        r_act_size  <= r_size_cfg;
                        r_state     <= S_DONE;
                    end
                end
                S_GET: begin
                    if (arith_rsp.done) begin
                        r_head    <= ram_rdata;
                        r_free    <= r_free - 9'd1;
                        r_granted <= arith_rsp.result;
                        r_state   <= S_DONE;
                    end
                end
                S_PUT: begin
                    if (arith_rsp.done) begin
                        if (put_bad) begin
                            r_status <= ST_INVALID;
                        end else if (put_full) begin
                            r_status <= ST_INVALID;
                            r_full   <= 1'b1;
                        end else begin
                            r_head <= arith_rsp.result[LW-1:0];
                            r_free <= r_free + 9'd1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.status          <= r_status;
                        r_out.pool_full       <= r_full;
                        r_out.granted_address <= r_granted;
                        r_out.free_blocks     <= r_free;
                        r_out.used_blocks     <= r_act_total - r_free;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

/* rtl/fbpa_checker.sv */
// fbpa_checker: port-level checks of the pool allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator_core

module fbpa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fbpa_pkg::t_out_word o_out_data
);
    import fbpa_pkg::*;

    // a result word waiting on the sink holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // the input is not ready again in the cycle after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

    a_addr_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.granted_address == 32'd0)
        else $error("address granted with a failing status");

    a_full_is_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pool_full |-> o_out_data.status == ST_INVALID)
        else $error("pool full flagged without invalid status");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/testbench.sv */
// testbench: directed and random regression of fixed_block_pool_allocator_core
// depends on fbpa_pkg and the core rtl; keeps its own free-list model as the scoreboard

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    class pool_scoreboard;
        t_out_word   expected_replies[$];
        logic [31:0] held_addresses[$];   // granted and not yet returned, steers puts
        int          mismatches;

        // register shadow, used at the next format
        logic [31:0] reg_base;
        logic [15:0] reg_size;
        logic [8:0]  reg_total;

        // pool in use
        logic [8:0]  link_ram [256];
        logic [8:0]  head;
        logic [8:0]  free_cnt;
        logic [8:0]  pool_total;
        logic [31:0] pool_base;
        logic [15:0] pool_size;

        function new();
            mismatches = 0;
            reg_base   = '0;
            reg_size   = RESET_BLOCK_BYTES;
            reg_total  = '0;
            foreach (link_ram[i]) link_ram[i] = '0;
            head       = 9'd256;
            free_cnt   = '0;
            pool_total = '0;
            pool_base  = '0;
            pool_size  = '0;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_BASE:  reg_base  = value;
                REG_SIZE:  reg_size  = value[15:0];
                REG_TOTAL: reg_total = value[8:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_BASE:  return reg_base;
                REG_SIZE:  return {16'h0, reg_size};
                REG_TOTAL: return {23'h0, reg_total};
                default:   return '0;
            endcase
        endfunction

        function logic [31:0] block_address(int idx);
            return pool_base + 32'(idx) * 32'(pool_size);
        endfunction

        // predicts the reply of one accepted word and updates the pool
        function void note_request(t_in_word w);
            t_out_word   r;
            logic [31:0] offset;
            logic [31:0] idx;
            int          hit[$];
            int          i;
            r = '0;
            case (w.cmd)
                CMD_GET: begin
                    if (free_cnt == 0 || head >= 9'd256) begin
                        r.status = ST_NO_FREE;
                    end else begin
                        r.granted_address = pool_base + 32'(head) * 32'(pool_size);
                        held_addresses.push_back(r.granted_address);
                        head = link_ram[head[7:0]];
                        free_cnt--;
                    end
                end
                CMD_PUT: begin
                    offset = w.return_address - pool_base;
                    if (pool_total == 0 || pool_size == 0) begin
                        r.status = ST_INVALID;
                    end else if (offset % 32'(pool_size) != 0) begin
                        r.status = ST_INVALID;
                    end else begin
                        idx = offset / 32'(pool_size);
                        if (idx >= 32'(pool_total) || idx >= 32'd256) begin
                            r.status = ST_INVALID;
                        end else if (free_cnt >= pool_total) begin
                            r.status    = ST_INVALID;
                            r.pool_full = 1'b1;
                        end else begin
                            link_ram[idx[7:0]] = head;
                            head = idx[8:0];
                            free_cnt++;
                            hit = held_addresses.find_first_index(a) with
                                (a == w.return_address);
                            if (hit.size() != 0) held_addresses.delete(hit[0]);
                        end
                    end
                end
                CMD_FMT: begin
                    if (reg_base == 0) begin
                        r.status = ST_BAD_BASE;
                    end else if (reg_total < MIN_BLOCKS || reg_total > 9'd256) begin
                        r.status = ST_BAD_COUNT;
                    end else if (reg_size < POINTER_BYTES) begin
                        r.status = ST_TOO_SMALL;
                    end else begin
                        for (i = 0; i < int'(reg_total); i++) begin
                            link_ram[i] = (i + 1 == int'(reg_total)) ? 9'd256 : 9'(i + 1);
                        end
                        head       = '0;
                        free_cnt   = reg_total;
                        pool_total = reg_total;
                        pool_base  = reg_base;
                        pool_size  = reg_size;
                        held_addresses.delete();
                    end
                end
                default: ;  // unknown command only reports the counts
            endcase
            r.free_blocks = free_cnt;
            r.used_blocks = pool_total - free_cnt;
            expected_replies.push_back(r);
        endfunction

        function void check_reply(t_out_word got);
            t_out_word want;
            if (expected_replies.size() == 0) begin
                note_mismatch($sformatf({"unexpected result: status %0d full %0d ",
                    "addr %h free %0d used %0d"},
                    got.status, got.pool_full, got.granted_address, got.free_blocks,
                    got.used_blocks));
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.pool_full !== want.pool_full ||
                    got.granted_address !== want.granted_address ||
                    got.free_blocks !== want.free_blocks ||
                    got.used_blocks !== want.used_blocks) begin
                note_mismatch($sformatf({"mismatch: expected status %0d full %0d addr %h ",
                    "free %0d used %0d, got status %0d full %0d addr %h free %0d used %0d"},
                    want.status, want.pool_full, want.granted_address, want.free_blocks,
                    want.used_blocks, got.status, got.pool_full, got.granted_address,
                    got.free_blocks, got.used_blocks));
            end
        endfunction

        function void check_leftovers();
            if (expected_replies.size() != 0) begin
                note_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_word          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_word         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pool_scoreboard pool_sb;
    int             burst_left;
    bit             hold_request;

    fixed_block_pool_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("fixed_block_pool_allocator_core regression: fail");
        $finish;
    end

    // result side: checks words and stalls on its own pattern
    initial begin : result_side
        int  mode;
        int  mode_left;
        int  hold_left;
        int  tick;
        int  stride;
        bit  nxt;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        stride    = 2;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) pool_sb.check_reply(o_out_data);
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
                nxt          = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(40, 300);
                    stride    = $urandom_range(2, 6);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: nxt = 1'b1;
                    1: nxt = ($urandom_range(0, 99) < 50);
                    2: nxt = (tick % stride == 0);
                    default: nxt = ($urandom_range(0, 99) < 90);
                endcase
            end
            i_out_ready <= nxt;
        end
    end

    task automatic apb_access(logic [1:0] idx, bit wr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr ? data : 32'h0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (!wr && prdata !== data) begin
            pool_sb.note_mismatch($sformatf("register %0d read %h, expected %h",
                idx, prdata, data));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        apb_access(idx, 1'b1, value);
        pool_sb.set_reg(idx, value);
        apb_access(idx, 1'b0, pool_sb.reg_value(idx));
    endtask

    // sender pauses until every expected result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pool_sb.expected_replies.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_pool(logic [31:0] base, logic [15:0] size, logic [8:0] total);
        drain_results();
        write_reg(REG_BASE, base);
        write_reg(REG_SIZE, {16'h0, size});
        write_reg(REG_TOTAL, {23'h0, total});
    endtask

    task automatic send_word(t_cmd c, logic [31:0] addr);
        t_in_word w;
        int       gap;
        w.cmd            = c;
        w.return_address = addr;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 2) ? 0 : $urandom_range(1, 40);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pool_sb.note_request(w);
    endtask

    // one pool setting: a format, then mostly gets and returns of granted blocks
    task automatic run_phase(int n);
        int          k;
        int          r;
        logic [31:0] addr;
        send_word(CMD_FMT, $urandom);
        for (k = 1; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40 || (r < 75 && pool_sb.held_addresses.size() == 0)) begin
                send_word(CMD_GET, $urandom);
            end else if (r < 75) begin
                addr = pool_sb.held_addresses[$urandom_range(0,
                    pool_sb.held_addresses.size() - 1)];
                send_word(CMD_PUT, addr);
            end else if (r < 80) begin
                // a block of the pool, which may be a double free, or the first index past the pool
                send_word(CMD_PUT, pool_sb.block_address($urandom_range(0,
                    int'(pool_sb.pool_total))));
            end else if (r < 86) begin
                send_word(CMD_PUT, $urandom);
            end else if (r < 90) begin
                addr = pool_sb.block_address($urandom_range(0, 255)) + $urandom_range(1, 7);
                send_word(CMD_PUT, addr);
            end else if (r < 93) begin
                send_word(CMD_PUT, pool_sb.block_address(int'(pool_sb.pool_total) +
                    $urandom_range(0, 300)));
            end else if (r < 96) begin
                send_word(CMD_NOP, $urandom);
            end else if (r < 98) begin
                send_word(CMD_FMT, $urandom);
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin : stimulus
        int          items;
        int          phase;
        int          n;
        int          r;
        int          wait_cnt;
        logic [31:0] b;
        logic [15:0] s;
        logic [8:0]  t;

        pool_sb      = new();
        burst_left   = 0;
        hold_request = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(REG_BASE, 1'b0, pool_sb.reg_value(REG_BASE));
        apb_access(REG_SIZE, 1'b0, pool_sb.reg_value(REG_SIZE));
        apb_access(REG_TOTAL, 1'b0, pool_sb.reg_value(REG_TOTAL));

        // nothing formatted yet, base still zero
        send_word(CMD_GET, 32'h0);
        send_word(CMD_PUT, 32'h0);
        send_word(CMD_NOP, 32'hFFFF_FFFF);
        send_word(CMD_FMT, 32'h0);
        drain_results();
        write_reg(REG_BASE, 32'hFFFF_FFF0);
        write_reg(REG_TOTAL, 32'd1);
        send_word(CMD_FMT, 32'h0);
        drain_results();
        write_reg(REG_TOTAL, 32'd257);
        send_word(CMD_FMT, 32'h0);
        drain_results();
        write_reg(REG_TOTAL, 32'd4);
        write_reg(REG_SIZE, 32'd7);
        send_word(CMD_FMT, 32'h0);
        drain_results();

        // four blocks wrapping past the top of the address space
        write_reg(REG_SIZE, 32'd8);
        send_word(CMD_FMT, 32'h0);
        repeat (5) send_word(CMD_GET, $urandom);
        send_word(CMD_PUT, 32'hFFFF_FFF1);
        send_word(CMD_PUT, 32'h0000_0010);
        send_word(CMD_PUT, 32'hFFFF_FFFF);
        send_word(CMD_PUT, 32'h0000_0000);
        send_word(CMD_PUT, 32'h0000_0000);
        send_word(CMD_PUT, 32'hFFFF_FFF0);
        send_word(CMD_PUT, 32'hFFFF_FFF8);
        send_word(CMD_PUT, 32'h0000_0008);
        // a refused format keeps the pool in use
        drain_results();
        write_reg(REG_BASE, 32'h0);
        send_word(CMD_FMT, 32'h0);
        send_word(CMD_GET, 32'h0);

        items = 0;
        phase = 0;
        while (items < 1800) begin
            if (phase == 0) begin
                b = $urandom | 32'h1;
                s = 16'hFFFF;
                t = 9'd256;
            end else if (phase == 1) begin
                b = 32'hFFFF_FFF8;
                s = POINTER_BYTES;
                t = MIN_BLOCKS;
            end else begin
                r = $urandom_range(0, 99);
                b = (r < 8) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF - $urandom_range(0, 4095)
                                               : $urandom;
                r = $urandom_range(0, 99);
                s = (r < 65) ? 16'($urandom_range(8, 64)) : (r < 75) ? 16'hFFFF
                  : (r < 85) ? 16'($urandom_range(0, 7)) : 16'($urandom);
                r = $urandom_range(0, 99);
                t = (r < 65) ? 9'($urandom_range(2, 12)) : (r < 75) ? 9'($urandom_range(13, 64))
                  : (r < 82) ? 9'd256 : (r < 91) ? 9'($urandom_range(0, 1))
                  : 9'($urandom_range(257, 511));
            end
            set_pool(b, s, t);
            // long receiver hold-off while the sender keeps offering words
            if (phase == 2) hold_request = 1'b1;
            n = (phase == 2) ? 60 : $urandom_range(20, 80);
            run_phase(n);
            items += n;
            phase++;
        end

        i_in_valid <= 1'b0;
        wait_cnt = 0;
        while (pool_sb.expected_replies.size() != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (300) @(posedge i_clk);
        pool_sb.check_leftovers();
        if (pool_sb.mismatches == 0) begin
            $display("fixed_block_pool_allocator_core regression: pass");
        end else begin
            $display("fixed_block_pool_allocator_core regression: fail");
        end
        $finish;
    end
endmodule

/* fixed_block_pool_allocator_core.f */
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_arith.sv
rtl/fixed_block_pool_allocator_core.sv
rtl/fbpa_checker.sv
test/testbench.sv
